[design/activation_function_unit_macros.svh]
// Assertion macros for the activation function unit.
// Used by activation_function_unit.sv; needs clk and rst in scope.
`ifndef ACTIVATION_FUNCTION_UNIT_MACROS_SVH
`define ACTIVATION_FUNCTION_UNIT_MACROS_SVH
`ifndef SYNTH
`define AFU_ASSERT_IMP(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("activation_function_unit: assertion failed");
`define AFU_ASSERT_NXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("activation_function_unit: assertion failed");
`else
`define AFU_ASSERT_IMP(lbl, pre, post)
`define AFU_ASSERT_NXT(lbl, pre, post)
`endif
`endif

[design/afu_pkg.sv]
// Shared types for the activation function unit.
// No dependencies.
package afu_pkg;

  typedef enum logic [1:0] {
    OP_RELU    = 2'd0,
    OP_TANH    = 2'd1,
    OP_SIGMOID = 2'd2
  } op_t;

  // Control that rides along with each sample through the pipeline.
  typedef struct packed {
    logic vld;
    op_t  op;
    logic last;
    logic neg;
  } ctl_t;

endpackage

[design/afu_front.sv]
// Front stages: sigmoid prescale, clamp, square, numerator and divisor.
// Depends on afu_pkg.
module afu_front #(
  parameter int DATA_WIDTH = 16,
  parameter int FRAC_BITS  = 10
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  afu_pkg::ctl_t                 ctl_in,
  input  logic signed [DATA_WIDTH-1:0]  x_in,
  output afu_pkg::ctl_t                 ctl_out,
  output logic signed [DATA_WIDTH-1:0]  x_out,
  output logic [2*FRAC_BITS+6:0]        num,
  output logic [FRAC_BITS+6:0]          den
);
  import afu_pkg::*;

  localparam int MAG_W = FRAC_BITS + 2;
  localparam int SQ_W  = FRAC_BITS + 4;
  localparam int T_W   = FRAC_BITS + 6;
  localparam int NUM_W = 2 * FRAC_BITS + 7;
  localparam int DEN_W = FRAC_BITS + 7;
  localparam int XW    = ((DATA_WIDTH > FRAC_BITS + 3) ? DATA_WIDTH : FRAC_BITS + 3) + 1;
  localparam logic signed [XW-1:0] LIM = XW'(3 * (2 ** FRAC_BITS));
  localparam logic [T_W-1:0]       K27 = T_W'(27 * (2 ** FRAC_BITS));

  // stage a: clamp and magnitude
  ctl_t                         ctl_a;
  logic signed [DATA_WIDTH-1:0] x_a;
  logic [MAG_W-1:0]             mag_a;
  // stage b: square
  ctl_t                         ctl_b;
  logic signed [DATA_WIDTH-1:0] x_b;
  logic [MAG_W-1:0]             mag_b;
  logic [SQ_W-1:0]              s_b;

  logic signed [DATA_WIDTH-1:0] h;
  logic signed [XW-1:0]         xe;
  logic signed [XW-1:0]         c;
  logic signed [XW-1:0]         abs_c;
  logic [2*MAG_W-1:0]           sq;
  logic [T_W-1:0]               t;
  logic [MAG_W+T_W-1:0]         prod;
  ctl_t                         ctl_a_next;

  always_comb begin
    // sigmoid works on tanh of x/2, floored
    h  = (ctl_in.op == OP_SIGMOID) ? (x_in >>> 1) : x_in;
    xe = XW'(h);
    if (xe > LIM) begin
      c = LIM;
    end else if (xe < -LIM) begin
      c = -LIM;
    end else begin
      c = xe;
    end
    abs_c = c[XW-1] ? -c : c;
    ctl_a_next     = ctl_in;
    ctl_a_next.neg = c[XW-1];
  end

  assign sq   = mag_a * mag_a;
  assign t    = K27 + T_W'(s_b);
  assign prod = mag_b * t;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_a   <= '0;
      ctl_b   <= '0;
      ctl_out <= '0;
    end else if (en) begin
      ctl_a   <= ctl_a_next;
      ctl_b   <= ctl_a;
      ctl_out <= ctl_b;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_a   <= x_in;
      mag_a <= abs_c[MAG_W-1:0];
      x_b   <= x_a;
      mag_b <= mag_a;
      s_b   <= sq[FRAC_BITS +: SQ_W];
      x_out <= x_b;
      num   <= prod[NUM_W-1:0];
      den   <= DEN_W'(K27) + (DEN_W'(s_b) << 3) + DEN_W'(s_b);
    end
  end

endmodule

[design/afu_div_cell.sv]
// One restoring-division cell: decides one quotient bit per cycle while en is high.
// Depends on afu_pkg.
module afu_div_cell #(
  parameter int DATA_WIDTH = 16,
  parameter int FRAC_BITS  = 10,
  parameter int SHIFT      = 0
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  afu_pkg::ctl_t                 ctl_in,
  input  logic signed [DATA_WIDTH-1:0]  x_in,
  input  logic [2*FRAC_BITS+6:0]        rem_in,
  input  logic [FRAC_BITS+6:0]          den_in,
  input  logic [FRAC_BITS+1:0]          q_in,
  output afu_pkg::ctl_t                 ctl_out,
  output logic signed [DATA_WIDTH-1:0]  x_out,
  output logic [2*FRAC_BITS+6:0]        rem_out,
  output logic [FRAC_BITS+6:0]          den_out,
  output logic [FRAC_BITS+1:0]          q_out
);
  import afu_pkg::*;

  localparam int NUM_W = 2 * FRAC_BITS + 7;
  localparam int DEN_W = FRAC_BITS + 7;
  localparam int QB    = FRAC_BITS + 2;
  localparam int CW    = DEN_W + QB;

  logic [CW-1:0]    trial;
  logic [CW-1:0]    diff;
  logic             ge;
  logic [QB-1:0]    q_next;

  always_comb begin
    trial  = CW'(den_in) << SHIFT;
    ge     = CW'(rem_in) >= trial;
    diff   = CW'(rem_in) - trial;
    q_next = q_in;
    q_next[SHIFT] = ge;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out <= '0;
    end else if (en) begin
      ctl_out <= ctl_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_out   <= x_in;
      den_out <= den_in;
      rem_out <= ge ? diff[NUM_W-1:0] : rem_in;
      q_out   <= q_next;
    end
  end

endmodule

[design/afu_back.sv]
// Output stage: sign, sigmoid offset, relu, op select and saturation.
// Depends on afu_pkg.
module afu_back #(
  parameter int DATA_WIDTH = 16,
  parameter int FRAC_BITS  = 10
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  afu_pkg::ctl_t                 ctl_in,
  input  logic signed [DATA_WIDTH-1:0]  x_in,
  input  logic [FRAC_BITS+1:0]          q_in,
  output afu_pkg::ctl_t                 ctl_out,
  output logic signed [DATA_WIDTH-1:0]  y
);
  import afu_pkg::*;

  localparam int RW = ((DATA_WIDTH > FRAC_BITS + 4) ? DATA_WIDTH : FRAC_BITS + 4) + 1;
  localparam logic signed [RW-1:0] ONE_R = RW'(2 ** FRAC_BITS);
  localparam logic signed [RW-1:0] HI    = {{(RW - DATA_WIDTH + 1){1'b0}},
                                            {(DATA_WIDTH - 1){1'b1}}};
  localparam logic signed [RW-1:0] LO    = ~HI;

  logic signed [RW-1:0] tq;
  logic signed [RW-1:0] th;
  logic signed [RW-1:0] sum;
  logic signed [RW-1:0] xe;
  logic signed [RW-1:0] sel;
  logic signed [RW-1:0] sat;

  always_comb begin
    tq  = RW'(q_in);
    th  = ctl_in.neg ? -tq : tq;
    sum = th + ONE_R;
    xe  = RW'(x_in);
    unique case (ctl_in.op)
      OP_RELU:    sel = xe[RW-1] ? '0 : xe;
      OP_TANH:    sel = th;
      OP_SIGMOID: sel = sum >>> 1;
      default:    sel = '0;
    endcase
    if (sel > HI) begin
      sat = HI;
    end else if (sel < LO) begin
      sat = LO;
    end else begin
      sat = sel;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out <= '0;
    end else if (en) begin
      ctl_out <= ctl_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      y <= sat[DATA_WIDTH-1:0];
    end
  end

endmodule

[design/activation_function_unit.sv]
// Activation function unit: relu, rational tanh and sigmoid on Q-format samples.
// Pipeline: 3 front stages, FRAC_BITS+2 divider cells, 1 output register.
// Throughput one transfer per cycle when the output is not stalled.
// The whole pipeline advances together; a stalled output freezes every stage.
// Synchronous active-high rst clears all valid/control flags; data regs are not reset.
// Depends on afu_pkg, afu_front, afu_div_cell, afu_back and the macros header.
`include "activation_function_unit_macros.svh"
module activation_function_unit #(
  parameter int DATA_WIDTH = 16,
  parameter int FRAC_BITS  = 10
) (
  input  logic                                   clk,
  input  logic                                   rst,
  // input stream
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  input  logic [((DATA_WIDTH + 7) / 8) * 8 - 1:0] s_axis_tdata,  // [DATA_WIDTH-1:0] x_value
  input  logic [1:0]                             s_axis_tuser,  // [1:0] op
  input  logic                                   s_axis_tlast,  // last_in
  // output stream
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  output logic [((DATA_WIDTH + 7) / 8) * 8 - 1:0] m_axis_tdata,  // [DATA_WIDTH-1:0] y_value
  output logic                                   m_axis_tlast   // last_out
);
  import afu_pkg::*;

  localparam int BUS_W = ((DATA_WIDTH + 7) / 8) * 8;
  localparam int NUM_W = 2 * FRAC_BITS + 7;
  localparam int DEN_W = FRAC_BITS + 7;
  localparam int QB    = FRAC_BITS + 2;  // quotient bits, one divider cell each

  // Global advance: every stage moves when the output register is empty or drained.
  logic en;

  ctl_t                         ctl_in;
  ctl_t                         ctl_out;
  logic signed [DATA_WIDTH-1:0] y;

  // Divider chain taps: index 0 is the front output, index QB the last cell.
  ctl_t                         ctl_c [QB+1];
  logic signed [DATA_WIDTH-1:0] x_c   [QB+1];
  logic [NUM_W-1:0]             rem_c [QB+1];
  logic [DEN_W-1:0]             den_c [QB+1];
  logic [QB-1:0]                q_c   [QB+1];

  assign en            = !ctl_out.vld || m_axis_tready;
  assign s_axis_tready = en;

  always_comb begin
    ctl_in.vld  = s_axis_tvalid;
    ctl_in.op   = op_t'(s_axis_tuser);
    ctl_in.last = s_axis_tlast;
    ctl_in.neg  = 1'b0;  // filled in after the clamp
  end

  afu_front #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .ctl_in  (ctl_in),
    .x_in    (s_axis_tdata[DATA_WIDTH-1:0]),
    .ctl_out (ctl_c[0]),
    .x_out   (x_c[0]),
    .num     (rem_c[0]),
    .den     (den_c[0])
  );

  assign q_c[0] = '0;

  // Quotient bits are resolved MSB first, one per cell.
  for (genvar i = 0; i < QB; i++) begin : g_cell
    afu_div_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .FRAC_BITS  (FRAC_BITS),
      .SHIFT      (QB - 1 - i)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .en      (en),
      .ctl_in  (ctl_c[i]),
      .x_in    (x_c[i]),
      .rem_in  (rem_c[i]),
      .den_in  (den_c[i]),
      .q_in    (q_c[i]),
      .ctl_out (ctl_c[i+1]),
      .x_out   (x_c[i+1]),
      .rem_out (rem_c[i+1]),
      .den_out (den_c[i+1]),
      .q_out   (q_c[i+1])
    );
  end

  afu_back #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .ctl_in  (ctl_c[QB]),
    .x_in    (x_c[QB]),
    .q_in    (q_c[QB]),
    .ctl_out (ctl_out),
    .y       (y)
  );

  assign m_axis_tvalid = ctl_out.vld;
  assign m_axis_tdata  = BUS_W'($unsigned(y));
  assign m_axis_tlast  = ctl_out.last;

  // Division is complete: leftover remainder is below the divisor.
  `AFU_ASSERT_IMP(a_rem_below_den, ctl_c[QB].vld, rem_c[QB] < NUM_W'(den_c[QB]))
  // Relu never yields a negative result.
  `AFU_ASSERT_IMP(a_relu_nonneg, ctl_out.vld && ctl_out.op == OP_RELU, !y[DATA_WIDTH-1])
  // Unused op code gives zero.
  `AFU_ASSERT_IMP(a_unused_zero,
                  ctl_out.vld && ctl_out.op != OP_RELU && ctl_out.op != OP_TANH &&
                  ctl_out.op != OP_SIGMOID, y == '0)
  // A stall freezes the chain, so the item behind the output is not dropped.
  `AFU_ASSERT_NXT(a_chain_holds, ctl_out.vld && !m_axis_tready && ctl_c[QB].vld, ctl_c[QB].vld)

endmodule
